[rtl/rrs_pkg.sv]
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and constants for the residual ratio statistics unit.
// ----------------------------------------------------------------------------
package rrs_pkg;

  // Run length limit: the lesser of the equation limit and the count field range
  localparam int unsigned MAX_EQUATIONS   = 65536;
  localparam int unsigned COUNT_FIELD_MAX = 131071;
  localparam logic [16:0] CountCap =
      17'((MAX_EQUATIONS < COUNT_FIELD_MAX) ? MAX_EQUATIONS : COUNT_FIELD_MAX);

  // Iteration counts of the serial units
  localparam logic [6:0] RatioSteps = 7'd31;
  localparam logic [6:0] MeanSteps  = 7'd64;
  localparam logic [5:0] RootSteps  = 6'd32;

  // Squares of the saturated ratios, Q32.32
  localparam logic [63:0] SqSatPos = 64'h3FFF_FFFF_0000_0001;
  localparam logic [63:0] SqSatNeg = 64'h4000_0000_0000_0000;

  typedef enum logic [3:0] {
    StIdle,
    StLoad,
    StRatio,
    StFold,
    StFinish,
    StMean,
    StRootGo,
    StRoot,
    StEmit
  } state_e;

  typedef struct packed {
    logic step;   // an iteration happens this cycle
    logic qbit;   // quotient bit produced by that iteration
    logic done;   // this is the final iteration
  } div_stat_t;

endpackage

[rtl/rrs_div.sv]
// ----------------------------------------------------------------------------
// rrs_div
// Radix-2 restoring divider: one quotient bit per cycle, dividend shifted in
// MSB first, quotient bits shifted into the freed low end.
// ----------------------------------------------------------------------------
module rrs_div
  import rrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] rem_i,
  input  logic [63:0] dvd_i,
  input  logic [30:0] dvs_i,
  input  logic [6:0]  steps_i,
  output div_stat_t   stat_o,
  output logic [63:0] quo_o
);

  logic [30:0] rem_q;
  logic [30:0] rem_d;
  logic [63:0] dvd_q;
  logic [30:0] dvs_q;
  logic [6:0]  cnt_q;
  logic [31:0] shifted;
  logic [31:0] diff;
  logic        ge;

  assign shifted = {rem_q, dvd_q[63]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = (shifted >= {1'b0, dvs_q});
  // Remainder stays below the divisor, so 31 bits hold it
  assign rem_d   = ge ? diff[30:0] : shifted[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= steps_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      dvd_q <= dvd_i;
      dvs_q <= dvs_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[62:0], ge};
    end
  end

  assign stat_o.step = (cnt_q != '0);
  assign stat_o.qbit = ge;
  assign stat_o.done = (cnt_q == 7'd1);
  assign quo_o       = dvd_q;

endmodule

[rtl/rrs_sqrt.sv]
// ----------------------------------------------------------------------------
// rrs_sqrt
// Digit-by-digit integer square root of a 64-bit radicand: two radicand
// bits in and one root bit out per cycle, floor result.
// ----------------------------------------------------------------------------
module rrs_sqrt
  import rrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] rad_q;
  logic [33:0] rem_q;
  logic [33:0] rem_d;
  logic [31:0] root_q;
  logic [5:0]  cnt_q;
  logic [35:0] shifted;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;

  assign shifted = {rem_q, rad_q[63:62]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign diff    = shifted - trial;
  assign ge      = (shifted >= trial);
  assign rem_d   = ge ? diff[33:0] : shifted[33:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= RootSteps;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= {root_q[30:0], ge};
    end
  end

  assign done_o = (cnt_q == 6'd1);
  assign root_o = root_q;

endmodule

[rtl/residual_ratio_statistics_unit.sv]
// ----------------------------------------------------------------------------
// residual_ratio_statistics_unit
// Running min, max (with equation index), count and RMS of residual/coef_sum
// ratios over a run of equations, signed Q16.16.
// ----------------------------------------------------------------------------
// One item at a time. A counted equation passes through a load state, the
// bit-serial divider (one quotient bit per cycle) and an update state before
// the next item can transfer; a ratio that saturates skips the divider, and a
// skipped equation skips both the divider and the update. The item that ends
// a run adds the mean division (square sum by count, in the same divider),
// the bit-serial square root and further control states, or the control
// states alone when the run is empty. The result sits in an output register,
// so the next run may start while it waits to be taken.
module residual_ratio_statistics_unit
  import rrs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        eq_index_i,
  input  logic signed [31:0] residual_i,
  input  logic signed [31:0] coef_sum_i,
  input  logic               selected_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [30:0]        rms_ratio_o,
  output logic signed [31:0] min_ratio_o,
  output logic signed [31:0] max_ratio_o,
  output logic [15:0]        min_at_o,
  output logic [15:0]        max_at_o,
  output logic [16:0]        active_count_o
);

  state_e state_q, state_d;

  // Latched item
  logic [15:0]        idx_q;
  logic signed [31:0] res_q;
  logic signed [31:0] den_q;
  logic               sel_q;
  logic               last_q;

  // Per-item ratio work
  logic [31:0] mag_q;
  logic        neg_q;
  logic [63:0] sq_q;

  // Run statistics
  logic [16:0]        count_q;
  logic signed [31:0] low_q;
  logic signed [31:0] high_q;
  logic [15:0]        low_idx_q;
  logic [15:0]        high_idx_q;
  logic [63:0]        ssum_q;

  logic out_valid_q;

  // Control
  logic        in_xfer;
  logic        counted;
  logic        ovf;
  logic [31:0] res_abs;
  logic        out_free;
  logic        emit_load;
  logic        div_start;
  logic        sqrt_start;

  // Serial units
  div_stat_t   div_stat;
  logic [30:0] div_rem;
  logic [63:0] div_dvd;
  logic [30:0] div_dvs;
  logic [6:0]  div_steps;
  logic [63:0] div_quo;
  logic        sqrt_done;
  logic [31:0] sqrt_root;

  // Fold and emit datapath
  logic signed [31:0] ratio;
  logic [64:0]        ssum_add;
  logic [30:0]        rms_val;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign res_abs  = res_q[31] ? 32'(-res_q) : 32'(res_q);
  assign counted  = sel_q && !den_q[31] && (den_q != '0) && (count_q < CountCap);
  // Quotient magnitude reaches 2^31 exactly when |res| >= den * 2^15
  assign ovf      = ({15'd0, res_abs} >= {1'b0, den_q[30:0], 15'd0});
  assign out_free = !out_valid_q || !out_stall_i;

  assign ratio    = neg_q ? $signed(-mag_q) : $signed(mag_q);
  assign ssum_add = {1'b0, ssum_q} + {1'b0, sq_q};
  assign rms_val  = (count_q == '0) ? 31'd0 :
                    (sqrt_root[31] ? 31'h7FFF_FFFF : sqrt_root[30:0]);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_xfer) state_d = StLoad;
      StLoad: begin
        if (counted) begin
          state_d = ovf ? StFold : StRatio;
        end else if (last_q) begin
          state_d = StFinish;
        end else begin
          state_d = StIdle;
        end
      end
      StRatio:  if (div_stat.done) state_d = StFold;
      StFold:   state_d = last_q ? StFinish : StIdle;
      StFinish: state_d = (count_q == '0) ? StEmit : StMean;
      StMean:   if (div_stat.done) state_d = StRootGo;
      StRootGo: state_d = StRoot;
      StRoot:   if (sqrt_done) state_d = StEmit;
      StEmit:   if (out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    emit_load  = 1'b0;
    unique case (state_q)
      StIdle:   in_stall_o = 1'b0;
      StLoad:   div_start  = counted && !ovf;
      StFinish: div_start  = (count_q != '0);
      StRootGo: sqrt_start = 1'b1;
      StEmit:   emit_load  = out_free;
      default: ;
    endcase
  end

  // Divider operands: ratio magnitude, or mean of squares
  always_comb begin
    if (state_q == StFinish) begin
      div_rem   = '0;
      div_dvd   = ssum_q;
      div_dvs   = {14'd0, count_q};
      div_steps = MeanSteps;
    end else begin
      div_rem   = {14'd0, res_abs[31:15]};
      div_dvd   = {res_abs[14:0], 16'd0, 33'd0};
      div_dvs   = den_q[30:0];
      div_steps = RatioSteps;
    end
  end

  rrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .dvd_i   (div_dvd),
    .dvs_i   (div_dvs),
    .steps_i (div_steps),
    .stat_o  (div_stat),
    .quo_o   (div_quo)
  );

  rrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (div_quo),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= emit_load || (out_valid_q && out_stall_i);
    end
  end

  // Input latch and per-item ratio work
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      idx_q  <= eq_index_i;
      res_q  <= residual_i;
      den_q  <= coef_sum_i;
      sel_q  <= selected_i;
      last_q <= last_i;
    end
    case (state_q)
      StLoad: begin
        neg_q <= res_q[31];
        if (ovf) begin
          // Clamp to the signed 32-bit range
          mag_q <= res_q[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          sq_q  <= res_q[31] ? SqSatNeg : SqSatPos;
        end else begin
          mag_q <= '0;
          sq_q  <= '0;
        end
      end
      StRatio: begin
        if (div_stat.step) begin
          // (2q+b)^2 = 4q^2 + b(4q+1)
          mag_q <= {mag_q[30:0], div_stat.qbit};
          sq_q  <= {sq_q[61:0], 2'b00} +
                   (div_stat.qbit ? {30'd0, mag_q, 2'b01} : 64'd0);
        end
      end
      default: ;
    endcase
  end

  // Run statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      low_q      <= '0;
      high_q     <= '0;
      low_idx_q  <= '0;
      high_idx_q <= '0;
      ssum_q     <= '0;
    end else if (state_q == StFold) begin
      if (count_q == '0) begin
        low_q      <= ratio;
        high_q     <= ratio;
        low_idx_q  <= idx_q;
        high_idx_q <= idx_q;
      end else if (ratio < low_q) begin
        low_q     <= ratio;
        low_idx_q <= idx_q;
      end else if (ratio > high_q) begin
        high_q     <= ratio;
        high_idx_q <= idx_q;
      end
      ssum_q  <= ssum_add[64] ? '1 : ssum_add[63:0];
      count_q <= count_q + 17'd1;
    end else if (emit_load) begin
      count_q    <= '0;
      low_q      <= '0;
      high_q     <= '0;
      low_idx_q  <= '0;
      high_idx_q <= '0;
      ssum_q     <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      rms_ratio_o    <= rms_val;
      min_ratio_o    <= low_q;
      max_ratio_o    <= high_q;
      min_at_o       <= low_idx_q;
      max_at_o       <= high_idx_q;
      active_count_o <= count_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/rrs_checker.sv]
// ----------------------------------------------------------------------------
// rrs_checker
// Port-level checks of the residual ratio statistics unit, bound to the top.
// ----------------------------------------------------------------------------
module rrs_checker
  import rrs_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [30:0]        rms_ratio_o,
  input logic signed [31:0] min_ratio_o,
  input logic signed [31:0] max_ratio_o,
  input logic [15:0]        min_at_o,
  input logic [15:0]        max_at_o,
  input logic [16:0]        active_count_o
);

  // A stalled result holds: valid, RMS, min, max and count stay stable
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rms_ratio_o) &&
      $stable(min_ratio_o) && $stable(max_ratio_o) && $stable(active_count_o))
    else $error("result changed while stalled");

  // The unit works on one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transfer taken before the first was processed");

  // An empty run reports all zeros
  a_empty_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (active_count_o == 17'd0) |->
      (rms_ratio_o == 31'd0) && (min_ratio_o == 32'sd0) && (max_ratio_o == 32'sd0) &&
      (min_at_o == 16'd0) && (max_at_o == 16'd0))
    else $error("empty run reported nonzero fields");

  // Min never exceeds max, and the count stays within the run limit
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (min_ratio_o <= max_ratio_o) && (active_count_o <= CountCap))
    else $error("min above max or count beyond the run limit");

endmodule

bind residual_ratio_statistics_unit rrs_checker u_rrs_checker (.*);

[verif/tb_residual_ratio_statistics_unit.sv]
// ----------------------------------------------------------------------------
// tb_residual_ratio_statistics_unit
// Self-checking bench for the residual ratio statistics unit. A built-in
// predictor folds every accepted equation into its own copy of the run state
// and queues the summary expected on each end of run. A monitor matches each
// summary transfer against the oldest queued one, field by field. The tests
// cover field extremes and corner cases, random runs, long output back
// pressure and a drained pause.
// ----------------------------------------------------------------------------
module tb_residual_ratio_statistics_unit
  import rrs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned DrainCycles   = 200;
  localparam int unsigned IdlePercent   = 6;

  typedef struct packed {
    logic [15:0]        idx;
    logic signed [31:0] residual;
    logic signed [31:0] coef_sum;
    logic               selected;
    logic               last;
  } equation_t;

  typedef struct packed {
    logic [30:0]        rms;
    logic signed [31:0] min_ratio;
    logic signed [31:0] max_ratio;
    logic [15:0]        min_at;
    logic [15:0]        max_at;
    logic [16:0]        count;
  } summary_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [15:0]        eq_index_i     = '0;
  logic signed [31:0] residual_i     = '0;
  logic signed [31:0] coef_sum_i     = '0;
  logic               selected_i     = 1'b0;
  logic               last_i         = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [30:0]        rms_ratio_o;
  logic signed [31:0] min_ratio_o;
  logic signed [31:0] max_ratio_o;
  logic [15:0]        min_at_o;
  logic [15:0]        max_at_o;
  logic [16:0]        active_count_o;

  // Predicted run state
  logic [16:0]        run_count   = '0;
  logic signed [31:0] run_low     = '0;
  logic signed [31:0] run_high    = '0;
  logic [15:0]        run_low_at  = '0;
  logic [15:0]        run_high_at = '0;
  logic [63:0]        run_sq_sum  = '0;

  summary_t    summary_q[$];
  int unsigned mismatches      = 0;
  int unsigned runs_checked    = 0;
  int unsigned items_sent      = 0;
  int unsigned items_counted   = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_served    = 0;
  int unsigned hold_left       = 0;
  logic        quiet           = 1'b0;

  residual_ratio_statistics_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .eq_index_i    (eq_index_i),
    .residual_i    (residual_i),
    .coef_sum_i    (coef_sum_i),
    .selected_i    (selected_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rms_ratio_o   (rms_ratio_o),
    .min_ratio_o   (min_ratio_o),
    .max_ratio_o   (max_ratio_o),
    .min_at_o      (min_at_o),
    .max_at_o      (max_at_o),
    .active_count_o(active_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic signed [31:0] q16_ratio(input logic signed [31:0] num,
                                                   input logic signed [31:0] den);
    longint scaled;
    longint quo;
    scaled = longint'(num) * 64'sd65536;
    quo    = scaled / longint'(den);
    if (quo > 64'sd2147483647) quo = 64'sd2147483647;
    if (quo < -64'sd2147483648) quo = -64'sd2147483648;
    return quo[31:0];
  endfunction

  function automatic logic [31:0] floor_sqrt64(input logic [63:0] x);
    logic [31:0] root;
    logic [31:0] cand;
    logic [63:0] sq;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (32'd1 << b);
      sq   = 64'(cand) * 64'(cand);
      if (sq <= x) root = cand;
    end
    return root;
  endfunction

  task automatic fold_equation(input equation_t eq);
    logic signed [31:0] r;
    logic [63:0]        sq;
    logic [64:0]        total;
    logic [31:0]        root;
    summary_t           s;
    if (eq.selected && $signed(eq.coef_sum) > 0 && run_count < CountCap) begin
      r = q16_ratio(eq.residual, eq.coef_sum);
      if (run_count == 0) begin
        run_low     = r;
        run_high    = r;
        run_low_at  = eq.idx;
        run_high_at = eq.idx;
      end else if (r < run_low) begin
        run_low    = r;
        run_low_at = eq.idx;
      end else if (r > run_high) begin
        run_high    = r;
        run_high_at = eq.idx;
      end
      sq    = 64'(longint'(r) * longint'(r));
      total = {1'b0, run_sq_sum} + {1'b0, sq};
      run_sq_sum = total[64] ? '1 : total[63:0];
      run_count++;
      items_counted++;
    end
    if (eq.last) begin
      s.rms = '0;
      if (run_count != 0) begin
        root  = floor_sqrt64(run_sq_sum / 64'(run_count));
        s.rms = (root > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : root[30:0];
      end
      s.min_ratio = run_low;
      s.max_ratio = run_high;
      s.min_at    = run_low_at;
      s.max_at    = run_high_at;
      s.count     = run_count;
      summary_q.push_back(s);
      run_count   = '0;
      run_low     = '0;
      run_high    = '0;
      run_low_at  = '0;
      run_high_at = '0;
      run_sq_sum  = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver side
  // --------------------------------------------------------------------------
  task automatic send_equation(input equation_t eq);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 99) < IdlePercent) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    eq_index_i = eq.idx;
    residual_i = eq.residual;
    coef_sum_i = eq.coef_sum;
    selected_i = eq.selected;
    last_i     = eq.last;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    fold_equation(eq);
  endtask

  task automatic send_fields(input logic [15:0] idx, input logic [31:0] res,
                             input logic [31:0] coef, input logic sel,
                             input logic last);
    equation_t eq;
    eq.idx      = idx;
    eq.residual = res;
    eq.coef_sum = coef;
    eq.selected = sel;
    eq.last     = last;
    send_equation(eq);
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drain();
    end_burst();
    while (summary_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_residual();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 32'h3FFFF);
      2: v = $urandom() >> $urandom_range(0, 31);
      3: begin
        case ($urandom_range(0, 4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'h0000_0001;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: v = $urandom() & 32'h00FF_FFFF;
    endcase
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [31:0] pick_positive_coef();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 32'h3FFFF);
      1: return ($urandom() >> $urandom_range(1, 31)) | 32'd1;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'd1;
      default: return $urandom_range(32'h8000, 32'h40000);
    endcase
  endfunction

  function automatic logic [31:0] pick_inactive_coef();
    case ($urandom_range(0, 2))
      0: return 32'd0;
      1: return 32'h8000_0000;
      default: return $urandom() | 32'h8000_0000;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side: random stalls, long hold-offs on request
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (holds_served != holds_requested) begin
      holds_served++;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = !quiet && ($urandom_range(0, 99) < IdlePercent);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    summary_t exp_s;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (summary_q.size() == 0) begin
        $error("unexpected summary transfer: count %0d", active_count_o);
        mismatches++;
      end else begin
        exp_s = summary_q.pop_front();
        runs_checked++;
        if (rms_ratio_o !== exp_s.rms) begin
          $error("rms_ratio mismatch: expected %0d, actual %0d", exp_s.rms, rms_ratio_o);
          mismatches++;
        end
        if (min_ratio_o !== exp_s.min_ratio) begin
          $error("min_ratio mismatch: expected %0d, actual %0d",
                 exp_s.min_ratio, min_ratio_o);
          mismatches++;
        end
        if (max_ratio_o !== exp_s.max_ratio) begin
          $error("max_ratio mismatch: expected %0d, actual %0d",
                 exp_s.max_ratio, max_ratio_o);
          mismatches++;
        end
        if (min_at_o !== exp_s.min_at) begin
          $error("min_at mismatch: expected %0d, actual %0d", exp_s.min_at, min_at_o);
          mismatches++;
        end
        if (max_at_o !== exp_s.max_at) begin
          $error("max_at mismatch: expected %0d, actual %0d", exp_s.max_at, max_at_o);
          mismatches++;
        end
        if (active_count_o !== exp_s.count) begin
          $error("active_count mismatch: expected %0d, actual %0d",
                 exp_s.count, active_count_o);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run: count cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("tb_residual_ratio_statistics_unit: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    // Empty runs: skipped item, then inactive sums of every kind
    send_fields(16'd0, 32'h0001_0000, 32'd1, 1'b0, 1'b1);
    send_fields(16'd5, 32'h0001_0000, 32'd0, 1'b1, 1'b0);
    send_fields(16'd6, 32'h0001_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_fields(16'd7, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1);
    // Field extremes, saturating ratios both ways
    send_fields(16'd0, 32'h7FFF_FFFF, 32'd1, 1'b1, 1'b0);
    send_fields(16'hFFFF, 32'h8000_0000, 32'd1, 1'b1, 1'b0);
    send_fields(16'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_fields(16'd2, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
    // Ties keep the first index
    send_fields(16'd10, 32'h0002_0000, 32'h0001_0000, 1'b1, 1'b0);
    send_fields(16'd11, 32'h0004_0000, 32'h0002_0000, 1'b1, 1'b0);
    send_fields(16'd12, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0);
    send_fields(16'd13, 32'h0000_8000, 32'h0000_8000, 1'b1, 1'b0);
    send_fields(16'd14, 32'h0003_0000, 32'h0001_0000, 1'b1, 1'b0);
    send_fields(16'd15, 32'h0006_0000, 32'h0002_0000, 1'b1, 1'b1);
    // Last item skipped still closes the run
    send_fields(16'd20, 32'h0001_2345, 32'h0000_1000, 1'b1, 1'b0);
    send_fields(16'd21, 32'hFFFF_B000, 32'h0000_3000, 1'b1, 1'b0);
    send_fields(16'd22, 32'h7FFF_FFFF, 32'd5, 1'b0, 1'b1);
    // Single-item runs, truncation toward zero
    send_fields(16'd30, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
    send_fields(16'd31, 32'hFFFF_0000, 32'h0003_0000, 1'b1, 1'b1);
    send_fields(16'd32, 32'h0000_0000, 32'h0000_0001, 1'b1, 1'b1);
    send_fields(16'hAAAA, 32'h5555_5555, 32'h2AAA_AAAA, 1'b1, 1'b1);
    end_burst();
  endtask

  task automatic test_random_runs(input int unsigned target);
    int unsigned sent;
    int unsigned len;
    int unsigned roll;
    equation_t   eq;
    logic [15:0] next_idx;
    logic [31:0] prev_res;
    logic [31:0] prev_coef;
    sent      = 0;
    prev_res  = 32'h0001_0000;
    prev_coef = 32'h0001_0000;
    while (sent < target) begin
      len      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      next_idx = 16'($urandom());
      for (int k = 0; k < len; k++) begin
        roll        = $urandom_range(0, 99);
        eq.idx      = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : next_idx;
        eq.residual = pick_residual();
        eq.coef_sum = pick_positive_coef();
        eq.selected = 1'b1;
        if (roll < 8) begin
          eq.selected = 1'b0;
        end else if (roll < 14) begin
          eq.coef_sum = pick_inactive_coef();
        end else if (roll < 17) begin
          eq.residual = $urandom();
          eq.coef_sum = $urandom();
          eq.selected = 1'($urandom_range(0, 1));
        end else if (roll < 27) begin
          // repeat a ratio to provoke ties
          eq.residual = prev_res;
          eq.coef_sum = prev_coef;
        end
        eq.last  = (k == len - 1);
        prev_res  = eq.residual;
        prev_coef = eq.coef_sum;
        next_idx++;
        quiet = (sent >= 400 && sent < 650);
        send_equation(eq);
        sent++;
      end
      if ($urandom_range(0, 24) == 0) wait_drain();
    end
    quiet = 1'b0;
    end_burst();
  endtask

  task automatic test_output_hold_off();
    int unsigned n;
    holds_requested++;
    for (int k = 0; k < 40; k++) begin
      n = $urandom_range(0, 3);
      send_fields(16'($urandom()), pick_residual(),
                  (n == 0) ? pick_positive_coef() : pick_inactive_coef(),
                  1'b1, k[0]);
    end
    end_burst();
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 6; k++)
      send_fields(16'(k), pick_residual(), pick_positive_coef(), 1'b1, k == 5);
    wait_drain();
    for (int k = 0; k < 6; k++)
      send_fields(16'(100 + k), pick_residual(), pick_positive_coef(), 1'b1, k == 5);
    end_burst();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_random_runs(1000);
    test_output_hold_off();
    test_drain_pause();

    wait_drain();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d equations (%0d counted) over %0d checked runs,",
             items_sent, items_counted, runs_checked);
    $display("including ties, empty runs, saturation, back pressure and a drained pause");
    if (mismatches == 0 && summary_q.size() == 0) begin
      $display("tb_residual_ratio_statistics_unit: PASS");
    end else begin
      $display("tb_residual_ratio_statistics_unit: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rrs_pkg.sv
rtl/rrs_div.sv
rtl/rrs_sqrt.sv
rtl/residual_ratio_statistics_unit.sv
rtl/rrs_checker.sv
verif/tb_residual_ratio_statistics_unit.sv
